FILE: hdl/dct_pkg.sv
// Package with the shared types and constants of the deferred call timer table.
package dct_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned KW = $clog2(MAX_RESULTS + 1);
    localparam int unsigned S_DATA_W = 168;
    localparam int unsigned M_DATA_W = 136;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_USER_W = 3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_CANCEL = 3'd1,
        OP_QUERY = 3'd2,
        OP_TICK = 3'd3,
        OP_LIST = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] fire_time;
        logic [31:0] handle;
        logic [31:0] value;
        logic [1:0]  flags;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
        logic        fire;
        logic [31:0] handle;
        logic        has_value;
        logic [31:0] value;
        logic        sgn;
        logic [31:0] remaining;
    } res_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_time;
        logic [31:0] call_id;
        logic [31:0] handle;
        logic [31:0] value;
        logic [1:0]  flags;
    } item_t;

endpackage

FILE: hdl/dct_div.sv
// Sequential scaler: computes ((t * 1000) mod 2^32) / m, one quotient bit per cycle.
module dct_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] t,
    input  logic [15:0] mult,
    output logic        done,
    output logic [31:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [16:0] trial;
    logic [16:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        trial = {r_reg, q_reg[31]};
        diff = trial - {1'b0, d_reg};
        if (start) begin
            q_next = (t << 10) - (t << 4) - (t << 3);
            r_next = '0;
            d_next = (mult == 16'd0) ? 16'd1 : mult;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = diff[15:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial[15:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: hdl/deferred_call_timer_table.sv
// Top level of the deferred call timer table.
// Commands arrive as beats on the s_ channel: s_tuser carries the opcode (add, cancel,
// query, tick, list) and s_tdata the operands. Each command gives one or more result
// beats on the m_ channel; m_tlast marks the final beat of a command. cfg_wr_en with
// cfg_wr_data sets the time multiplier; write it only while the block is idle.
// Pending calls live in a table memory with one read and one write port, kept packed
// in insertion order. One command is worked at a time. An add with a non-zero delay
// waits for the bit-serial scaler. Cancel, query and list read the table slot by slot;
// a removal shifts later slots down one by one, and a query that needs the scaler waits
// for it. Ticks visit each slot and shift the later slots down after each fired slot. A
// result beat can wait in the output register while the next is formed; when the
// receiver stalls, the block waits where it would push a further beat and resumes when
// m_tready returns. The next command is taken once the last result beat of the current
// one sits in the output register. Reset empties the table, clears the id counter and
// sets the multiplier to one; no clearing pass is needed.
module deferred_call_timer_table #(
    parameter int unsigned TABLE_DEPTH = dct_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_time, delay, call_id, handle, has_value, arg_value, arg_signed, zero pad
    input  logic [dct_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [dct_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_id, out_handle, out_has_value, out_value, out_signed, remaining, zero pad
    output logic [dct_pkg::M_DATA_W-1:0]  m_tdata,
    // status, fire
    output logic [dct_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned KW = dct_pkg::KW;

    dct_pkg::entry_t mem [TABLE_DEPTH];
    dct_pkg::entry_t rdata_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    dct_pkg::entry_t mem_wd;

    dct_pkg::state_t state_reg, state_next;
    dct_pkg::item_t  item_reg, item_next;
    dct_pkg::entry_t hold_reg, hold_next;
    dct_pkg::res_t   pend_reg, pend_next;
    dct_pkg::res_t   out_reg, out_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg, out_last_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [31:0]     last_id_reg, last_id_next;
    logic [15:0]     mult_reg;

    logic            div_start;
    logic [31:0]     div_t;
    logic            div_done;
    logic [31:0]     div_quot;

    logic            out_free;
    logic            can_push;
    logic            push;
    dct_pkg::res_t   res_new;
    logic            start_rm;
    logic            rm_done;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   j_inc;
    logic [CW:0]     j_inc2;
    logic [CW-1:0]   n_dec;
    logic [2:0]      s_op;
    logic [31:0]     s_delay;
    logic            s_hasv;
    dct_pkg::entry_t e;

    dct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .t       (div_t),
        .mult    (mult_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dct_pkg::S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg <= '0;
            last_id_reg <= '0;
            mult_reg <= 16'd1;
        end else begin
            state_reg <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
            n_reg <= n_next;
            last_id_reg <= last_id_next;
            if (cfg_wr_en) begin
                mult_reg <= cfg_wr_data;
            end
        end
        item_reg <= item_next;
        hold_reg <= hold_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
        out_last_reg <= out_last_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    assign s_op = s_tuser[2:0];
    assign s_delay = s_tdata[63:32];
    assign s_hasv = s_tdata[128];
    assign out_free = !out_valid_reg || m_tready;
    assign can_push = !pend_valid_reg || out_free;
    assign i_inc = i_reg + CW'(1);
    assign j_inc = j_reg + CW'(1);
    assign j_inc2 = {1'b0, j_reg} + (CW + 1)'(2);
    assign n_dec = n_reg - CW'(1);
    assign e = rdata_reg;
    assign rd_addr = (state_reg == dct_pkg::S_SHIFT_RD) ? j_inc[AW-1:0] : i_reg[AW-1:0];

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        hold_next = hold_reg;
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next = out_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        last_id_next = last_id_reg;
        mem_we = 1'b0;
        mem_wa = n_reg[AW-1:0];
        mem_wd = rdata_reg;
        div_start = 1'b0;
        div_t = s_delay;
        push = 1'b0;
        res_new = '0;
        start_rm = 1'b0;
        rm_done = 1'b0;

        case (state_reg)
            dct_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    item_next.opcode = s_op;
                    item_next.now_time = s_tdata[31:0];
                    item_next.call_id = s_tdata[95:64];
                    item_next.handle = s_tdata[127:96];
                    item_next.value = s_hasv ? s_tdata[160:129] : 32'd0;
                    item_next.flags = s_hasv ? {s_tdata[161], 1'b1} : 2'b00;
                    i_next = '0;
                    k_next = '0;
                    state_next = dct_pkg::S_FLUSH;
                    push = 1'b1;
                    res_new.status = dct_pkg::ST_NONE;
                    case (s_op)
                        dct_pkg::OP_ADD: begin
                            if (s_delay == 32'd0) begin
                                res_new.status = dct_pkg::ST_OK;
                                res_new.fire = 1'b1;
                                res_new.handle = s_tdata[127:96];
                                res_new.has_value = s_hasv;
                                res_new.value = s_hasv ? s_tdata[160:129] : 32'd0;
                                res_new.sgn = s_hasv & s_tdata[161];
                            end else if (n_reg >= CW'(TABLE_DEPTH)) begin
                                res_new.status = dct_pkg::ST_FULL;
                            end else begin
                                push = 1'b0;
                                div_start = 1'b1;
                                state_next = dct_pkg::S_DIV_WAIT;
                            end
                        end
                        dct_pkg::OP_CANCEL, dct_pkg::OP_QUERY,
                        dct_pkg::OP_TICK, dct_pkg::OP_LIST: begin
                            if (n_reg != '0) begin
                                push = 1'b0;
                                state_next = dct_pkg::S_SCAN_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dct_pkg::S_SCAN_RD: begin
                state_next = dct_pkg::S_SCAN_CHK;
            end
            dct_pkg::S_SCAN_CHK: begin
                case (item_reg.opcode)
                    dct_pkg::OP_CANCEL, dct_pkg::OP_QUERY: begin
                        if (e.id == item_reg.call_id) begin
                            if (item_reg.opcode == dct_pkg::OP_CANCEL) begin
                                push = 1'b1;
                                res_new.id = e.id;
                                start_rm = 1'b1;
                            end else if (e.fire_time > item_reg.now_time) begin
                                hold_next = e;
                                div_t = e.fire_time - item_reg.now_time;
                                div_start = 1'b1;
                                state_next = dct_pkg::S_DIV_WAIT;
                            end else begin
                                push = 1'b1;
                                res_new.id = e.id;
                                res_new.handle = e.handle;
                                res_new.has_value = e.flags[0];
                                res_new.value = e.value;
                                res_new.sgn = e.flags[1];
                                state_next = dct_pkg::S_FLUSH;
                            end
                        end else begin
                            i_next = i_inc;
                            if (i_inc >= n_reg) begin
                                push = 1'b1;
                                res_new.status = dct_pkg::ST_NONE;
                                state_next = dct_pkg::S_FLUSH;
                            end else begin
                                state_next = dct_pkg::S_SCAN_RD;
                            end
                        end
                    end
                    dct_pkg::OP_TICK: begin
                        if (item_reg.now_time >= e.fire_time) begin
                            if (can_push) begin
                                push = 1'b1;
                                res_new.id = e.id;
                                res_new.fire = 1'b1;
                                res_new.handle = e.handle;
                                res_new.has_value = e.flags[0];
                                res_new.value = e.value;
                                res_new.sgn = e.flags[1];
                                k_next = k_reg + KW'(1);
                                start_rm = 1'b1;
                            end
                        end else begin
                            i_next = i_inc;
                            if (i_inc >= n_reg) begin
                                state_next = dct_pkg::S_FLUSH;
                                if (k_reg == '0) begin
                                    push = 1'b1;
                                    res_new.status = dct_pkg::ST_NONE;
                                end
                            end else begin
                                state_next = dct_pkg::S_SCAN_RD;
                            end
                        end
                    end
                    default: begin
                        if (can_push) begin
                            push = 1'b1;
                            res_new.id = e.id;
                            i_next = i_inc;
                            k_next = k_reg + KW'(1);
                            if (i_inc >= n_reg || k_next >= KW'(dct_pkg::MAX_RESULTS)) begin
                                state_next = dct_pkg::S_FLUSH;
                            end else begin
                                state_next = dct_pkg::S_SCAN_RD;
                            end
                        end
                    end
                endcase
            end
            dct_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    push = 1'b1;
                    state_next = dct_pkg::S_FLUSH;
                    if (item_reg.opcode == dct_pkg::OP_ADD) begin
                        last_id_next = last_id_reg + 32'd1;
                        mem_we = 1'b1;
                        mem_wa = n_reg[AW-1:0];
                        mem_wd.id = last_id_next;
                        mem_wd.fire_time = item_reg.now_time + div_quot;
                        mem_wd.handle = item_reg.handle;
                        mem_wd.value = item_reg.value;
                        mem_wd.flags = item_reg.flags;
                        n_next = n_reg + CW'(1);
                        res_new.id = last_id_next;
                    end else begin
                        res_new.id = hold_reg.id;
                        res_new.handle = hold_reg.handle;
                        res_new.has_value = hold_reg.flags[0];
                        res_new.value = hold_reg.value;
                        res_new.sgn = hold_reg.flags[1];
                        res_new.remaining = div_quot;
                    end
                end
            end
            dct_pkg::S_SHIFT_RD: begin
                state_next = dct_pkg::S_SHIFT_WR;
            end
            dct_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wa = j_reg[AW-1:0];
                mem_wd = rdata_reg;
                j_next = j_inc;
                if (j_inc2 < {1'b0, n_reg}) begin
                    state_next = dct_pkg::S_SHIFT_RD;
                end else begin
                    rm_done = 1'b1;
                end
            end
            dct_pkg::S_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = pend_reg;
                    out_last_next = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = dct_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dct_pkg::S_IDLE;
            end
        endcase

        if (start_rm) begin
            j_next = i_reg;
            if (i_inc < n_reg) begin
                state_next = dct_pkg::S_SHIFT_RD;
            end else begin
                rm_done = 1'b1;
            end
        end

        if (rm_done) begin
            n_next = n_dec;
            if (item_reg.opcode == dct_pkg::OP_TICK && i_reg < n_dec
                    && k_next < KW'(dct_pkg::MAX_RESULTS)) begin
                state_next = dct_pkg::S_SCAN_RD;
            end else begin
                state_next = dct_pkg::S_FLUSH;
            end
        end

        if (push) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next = pend_reg;
                out_last_next = 1'b0;
            end
            pend_next = res_new;
            pend_valid_next = 1'b1;
        end
    end

    assign s_tready = (state_reg == dct_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = {out_reg.fire, out_reg.status};
    assign m_tdata = {6'd0, out_reg.remaining, out_reg.sgn, out_reg.value,
                      out_reg.has_value, out_reg.handle, out_reg.id};

endmodule

FILE: hdl/dct_check.sv
// Port checker of the deferred call timer table and its bind statement.
module dct_check (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dct_pkg::M_DATA_W-1:0] m_tdata,
    input logic [dct_pkg::M_USER_W-1:0] m_tuser,
    input logic                         m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result beat changed.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Command taken while another is in work.");

    a_full_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == dct_pkg::ST_FULL |-> m_tlast && !m_tuser[2])
        else $error("Table full beat is not a lone final beat.");

    a_fire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == dct_pkg::ST_OK)
        else $error("Fired call beat carries a failure status.");

endmodule

bind deferred_call_timer_table dct_check u_dct_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
